// ===== sv/elevator_request_scheduler_defines.svh =====
// Assertion macros used by the scheduler RTL.
`ifndef ELEVATOR_REQUEST_SCHEDULER_DEFINES_SVH
`define ELEVATOR_REQUEST_SCHEDULER_DEFINES_SVH

`ifndef ASSERT_OFF

`define ERS_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("elevator_request_scheduler: invariant violated");

`define ERS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("elevator_request_scheduler: sequence check failed");

`else

`define ERS_ASSERT_ALWAYS(label, clk, rst, cond)

`define ERS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== sv/ers_pkg.sv =====
`default_nettype none

package ers_pkg;

   typedef struct packed {
      logic        func;
      logic [31:0] sector;
      logic [7:0]  tag;
      logic [7:0]  block_count;
      logic        is_write;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [7:0]  out_tag;
      logic [31:0] out_sector;
      logic [7:0]  out_count;
      logic        out_write;
   } rsp_type;

   typedef struct packed {
      logic [31:0] sector;
      logic [7:0]  tag;
      logic [7:0]  block_count;
      logic        is_write;
   } entry_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      entry_type   fresh;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_EMIT
   } state_type;

   localparam logic FUNC_SUBMIT     = 1'b0;
   localparam logic FUNC_COMPLETE   = 1'b1;
   localparam logic STATUS_ISSUED   = 1'b0;
   localparam logic STATUS_REJECTED = 1'b1;

endpackage

`default_nettype wire

// ===== sv/ers_cell.sv =====
`default_nettype none

module ers_cell #(
   parameter int QUEUE_DEPTH = 16,
   parameter int INDEX       = 0
) (
   input  logic                               clock,
   input  ers_pkg::cell_ctrl_type             ctrl,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   occupancy,
   input  logic [$clog2(QUEUE_DEPTH)-1:0]     serve_idx,
   input  logic                               left_le,
   input  ers_pkg::entry_type                 left_entry,
   input  ers_pkg::entry_type                 right_entry,
   output logic                               le,
   output ers_pkg::entry_type                 entry
);
   import ers_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam logic [CW-1:0] SLOT    = CW'(INDEX);
   localparam logic [IW-1:0] SLOT_IX = IW'(INDEX);

   entry_type entry_ff;
   entry_type entry_in;
   logic      valid;

   assign valid = SLOT < occupancy;

   // The queue is sorted, so the cells whose sector is at or below the new one form a prefix.
   assign le    = valid && (entry_ff.sector <= ctrl.fresh.sector);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      case (ctrl.op)
         CELL_HOLD: begin
            entry_in = entry_ff;
         end
         CELL_INSERT: begin
            // The first cell past the prefix takes the new entry, the rest shift up by one.
            if (!le) begin
               entry_in = left_le ? ctrl.fresh : left_entry;
            end
         end
         CELL_REMOVE: begin
            if (SLOT_IX >= serve_idx) begin
               entry_in = right_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

// ===== sv/elevator_request_scheduler.sv =====
`default_nettype none

// Elevator (SCAN) scheduler for block requests.
// The req_ channel carries a submit (func 0) or the completion of the request in service
// (func 1). The rsp_ channel returns at most one result per item: the request now issued
// to the device (status 0) or an echo of a submit that found the queue full (status 1).
// Pending requests sit in a row of QUEUE_DEPTH cells kept sorted by sector; an insert or
// a removal shifts every affected cell by one place toward its neighbor.
// An item is taken in ST_IDLE, applied to the cells in ST_EXEC, and an item with a
// result loads the output register in ST_EMIT once that register is free. A new item
// is accepted only after the previous one has passed through these states back to
// ST_IDLE; all cells are driven by the single shared cell-update control.
// The output register lets the next item be accepted while a result still waits; a
// result that cannot be loaded because the receiver stalls holds the block until the
// earlier transfer completes.
// Synchronous reset empties the queue, sets the sweep direction up and drops any
// pending result. Queue contents are not cleared.

`include "elevator_request_scheduler_defines.svh"

module elevator_request_scheduler #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ers_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ers_pkg::rsp_type rsp_data
);
   import ers_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int IW = $clog2(QUEUE_DEPTH);

   state_type     state_ff, state_in;
   req_type       req_ff, req_in;
   logic [CW-1:0] occ_ff, occ_in;
   logic [IW-1:0] sp_ff, sp_in;
   logic          up_ff, up_in;
   logic          busy_ff, busy_in;
   logic          reject_ff, reject_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   cell_ctrl_type cell_ctrl;
   logic          le_vec [QUEUE_DEPTH];
   entry_type     entry_q [QUEUE_DEPTH];
   entry_type     served;

   logic          rsp_free;
   logic          has_result;
   logic [CW-1:0] sp_ext;
   logic          at_last;
   logic          at_first;
   logic          dir_next;

   genvar gi;
   generate
      for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
         logic      left_le;
         entry_type left_entry;
         entry_type right_entry;

         if (gi == 0) begin : g_head
            assign left_le    = 1'b1;
            assign left_entry = '0;
         end else begin : g_body
            assign left_le    = le_vec[gi-1];
            assign left_entry = entry_q[gi-1];
         end

         if (gi == QUEUE_DEPTH - 1) begin : g_tail
            assign right_entry = '0;
         end else begin : g_inner
            assign right_entry = entry_q[gi+1];
         end

         ers_cell #(
            .QUEUE_DEPTH (QUEUE_DEPTH),
            .INDEX       (gi)
         ) u_cell (
            .clock       (clock),
            .ctrl        (cell_ctrl),
            .occupancy   (occ_ff),
            .serve_idx   (sp_ff),
            .left_le     (left_le),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .le          (le_vec[gi]),
            .entry       (entry_q[gi])
         );
      end
   endgenerate

   assign served   = entry_q[sp_ff];
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign sp_ext   = CW'(sp_ff);
   assign at_last  = (sp_ext + CW'(1)) == occ_ff;
   assign at_first = sp_ff == '0;

   // The sweep turns around when the served entry is at the end it is moving toward.
   always_comb begin
      if (up_ff && at_last) begin
         dir_next = 1'b0;
      end else if (!up_ff && at_first) begin
         dir_next = 1'b1;
      end else begin
         dir_next = up_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = has_result ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready        = state_ff == ST_IDLE;
      req_in           = req_ff;
      occ_in           = occ_ff;
      sp_in            = sp_ff;
      up_in            = up_ff;
      busy_in          = busy_ff;
      reject_in        = reject_ff;
      has_result       = 1'b0;
      rsp_in           = rsp_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      cell_ctrl.op     = CELL_HOLD;
      cell_ctrl.fresh  = '{sector: req_ff.sector, tag: req_ff.tag,
                           block_count: req_ff.block_count, is_write: req_ff.is_write};

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
            end
         end
         ST_EXEC: begin
            reject_in = 1'b0;
            if (req_ff.func == FUNC_SUBMIT) begin
               if (occ_ff == CW'(QUEUE_DEPTH)) begin
                  reject_in  = 1'b1;
                  has_result = 1'b1;
               end else begin
                  cell_ctrl.op = CELL_INSERT;
                  occ_in       = CW'(occ_ff + CW'(1));
                  if (occ_ff == '0) begin
                     busy_in    = 1'b1;
                     sp_in      = '0;
                     has_result = 1'b1;
                  end else if (busy_ff && !le_vec[sp_ff]) begin
                     // The new entry lands at or below the one in service.
                     sp_in = IW'(sp_ff + IW'(1));
                  end
               end
            end else if (busy_ff && (occ_ff != '0) && (sp_ext < occ_ff)) begin
               cell_ctrl.op = CELL_REMOVE;
               occ_in       = CW'(occ_ff - CW'(1));
               up_in        = dir_next;
               if (occ_ff == CW'(1)) begin
                  busy_in = 1'b0;
                  sp_in   = '0;
               end else begin
                  sp_in      = dir_next ? sp_ff : IW'(sp_ff - IW'(1));
                  has_result = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (reject_ff) begin
                  rsp_in = '{status: STATUS_REJECTED, out_tag: req_ff.tag,
                             out_sector: req_ff.sector, out_count: req_ff.block_count,
                             out_write: req_ff.is_write};
               end else begin
                  rsp_in = '{status: STATUS_ISSUED, out_tag: served.tag,
                             out_sector: served.sector, out_count: served.block_count,
                             out_write: served.is_write};
               end
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         sp_ff        <= '0;
         up_ff        <= 1'b1;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         sp_ff        <= sp_in;
         up_ff        <= up_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      reject_ff <= reject_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ERS_ASSERT_ALWAYS(a_busy_tracks_occ, clock, reset, busy_ff == (occ_ff != '0))
   `ERS_ASSERT_ALWAYS(a_serve_in_range, clock, reset, !busy_ff || (sp_ext < occ_ff))
   `ERS_ASSERT_ALWAYS(a_occ_bound, clock, reset, occ_ff <= CW'(QUEUE_DEPTH))
   `ERS_ASSERT_NEXT(a_issue_keeps_busy, clock, reset, (state_ff == ST_EMIT) && !reject_ff, busy_ff)

endmodule

`default_nettype wire

// ===== tb/sv/scan_issue_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels of the scheduler, keeps its own sorted copy of the pending
// requests and the sweep state, and compares every result transfer with the oldest
// issue or rejection that the accepted requests call for.
module scan_issue_checker #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  ers_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  ers_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending_count,
   output int               queue_level
);
   import ers_pkg::*;

   entry_type slots [QUEUE_DEPTH];
   int        fill = 0;
   int        serving = 0;
   bit        heading_up = 1'b1;
   bit        busy = 1'b0;
   rsp_type   due_issues [$];
   int        mismatches = 0;
   int        waiting = 0;

   assign fail_count    = mismatches;
   assign pending_count = waiting;
   assign queue_level   = fill;

   function automatic rsp_type issue_of(entry_type e);
      rsp_type r;
      r.status     = STATUS_ISSUED;
      r.out_tag    = e.tag;
      r.out_sector = e.sector;
      r.out_count  = e.block_count;
      r.out_write  = e.is_write;
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      mismatches++;
   endtask

   // Applies one accepted request to the shadow queue and records the result it causes.
   task automatic advance_schedule(input req_type item);
      entry_type fresh;
      rsp_type   echo;
      int        pos;
      int        nxt;
      int        p;
      int        i;
      fresh.sector      = item.sector;
      fresh.tag         = item.tag;
      fresh.block_count = item.block_count;
      fresh.is_write    = item.is_write;
      if (item.func == FUNC_SUBMIT) begin
         if (fill >= QUEUE_DEPTH) begin
            echo = issue_of(fresh);
            echo.status = STATUS_REJECTED;
            due_issues.push_back(echo);
         end else begin
            // Equal sectors go behind the entries already holding that sector.
            pos = 0;
            while (pos < fill && slots[pos].sector <= item.sector) pos++;
            for (i = fill; i > pos; i--) slots[i] = slots[i - 1];
            slots[pos] = fresh;
            fill++;
            if (fill == 1) begin
               busy = 1'b1;
               serving = pos;
               due_issues.push_back(issue_of(slots[pos]));
            end else if (busy && pos <= serving) begin
               serving++;
            end
         end
      end else if (busy && fill != 0 && serving < fill) begin
         p = serving;
         if (heading_up && p + 1 == fill) begin
            heading_up = 1'b0;
         end else if (!heading_up && p == 0) begin
            heading_up = 1'b1;
         end
         nxt = heading_up ? p + 1 : p - 1;
         for (i = p; i + 1 < fill; i++) slots[i] = slots[i + 1];
         if (nxt >= 0 && nxt < fill) begin
            // The removal shifted everything above the served entry down by one.
            if (nxt > p) nxt--;
            fill--;
            serving = nxt;
            busy = 1'b1;
            due_issues.push_back(issue_of(slots[nxt]));
         end else begin
            fill--;
            busy = 1'b0;
            serving = 0;
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         fill = 0;
         serving = 0;
         heading_up = 1'b1;
         busy = 1'b0;
         due_issues.delete();
      end else begin
         // A result can never stem from a request taken at the same edge.
         if (rsp_valid && rsp_ready) begin
            if (due_issues.size() == 0) begin
               report_mismatch($sformatf("result with tag %0d sector %0h while none is due",
                                         rsp_data.out_tag, rsp_data.out_sector));
            end else begin
               want = due_issues.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch($sformatf("status %0b, expected %0b",
                                            rsp_data.status, want.status));
               if (rsp_data.out_tag !== want.out_tag)
                  report_mismatch($sformatf("tag %0d, expected %0d",
                                            rsp_data.out_tag, want.out_tag));
               if (rsp_data.out_sector !== want.out_sector)
                  report_mismatch($sformatf("sector %0h, expected %0h",
                                            rsp_data.out_sector, want.out_sector));
               if (rsp_data.out_count !== want.out_count)
                  report_mismatch($sformatf("count %0d, expected %0d",
                                            rsp_data.out_count, want.out_count));
               if (rsp_data.out_write !== want.out_write)
                  report_mismatch($sformatf("write flag %0b, expected %0b",
                                            rsp_data.out_write, want.out_write));
            end
         end
         if (req_valid && req_ready) advance_schedule(req_data);
      end
      waiting = due_issues.size();
   end

endmodule

// ===== tb/sv/tb_elevator_request_scheduler.sv =====
`timescale 1ns / 100ps

module tb_elevator_request_scheduler;
   import ers_pkg::*;

   localparam int QUEUE_DEPTH   = 16;
   localparam int ITEM_TARGET   = 800;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 16;
   localparam int DRAIN_LIMIT   = 20000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_count;
   int      queue_level;
   bit      steady = 1'b0;
   bit      hold_request = 1'b0;

   elevator_request_scheduler #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   scan_issue_checker #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) i_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .fail_count(fail_count),
      .pending_count(pending_count),
      .queue_level(queue_level)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #1_600_000;
      $display("CHECK FAILED");
      $finish;
   end

   // Result side: random back-pressure (none while steady), or a long hold-off when one is requested.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady || ($urandom_range(99) >= 11);
         end
      end
   end

   function automatic logic [31:0] pick_sector();
      case ($urandom_range(3))
         0: return $urandom();
         1: return $urandom_range(7);
         2: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
         default: return 32'hFFFF_FFF8 | $urandom_range(7);
      endcase
   endfunction

   function automatic req_type submit_of(logic [31:0] sector, logic [7:0] tag,
                                         logic [7:0] count, logic wr);
      req_type r;
      r.func        = FUNC_SUBMIT;
      r.sector      = sector;
      r.tag         = tag;
      r.block_count = count;
      r.is_write    = wr;
      return r;
   endfunction

   // Completions carry random junk in the fields the block must ignore.
   function automatic req_type completion();
      req_type r;
      r = submit_of($urandom(), 8'($urandom()), 8'($urandom()), 1'($urandom_range(1)));
      r.func = FUNC_COMPLETE;
      return r;
   endfunction

   function automatic req_type random_submit();
      return submit_of(pick_sector(), 8'($urandom()), 8'($urandom()),
                       1'($urandom_range(1)));
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_item(input req_type item);
      while (!steady && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic wait_all_issued();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      int      counted;
      int      phase;
      int      span;
      int      submit_pct;
      int      waited;
      bit      do_submit;
      req_type item;
      req_valid = 1'b0;
      req_data  = '0;
      reset     = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Completion with nothing in service, then a short sweep over the extremes.
      send_item(completion());
      send_item(submit_of(32'h8000_0000, 8'd1, 8'h10, 1'b0));
      send_item(submit_of(32'h0, 8'd0, 8'h00, 1'b0));
      send_item(submit_of(32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b1));
      send_item(submit_of(32'h8000_0000, 8'd2, 8'h01, 1'b1));
      repeat (4) send_item(completion());
      // Fill the queue to the brim, then one submit that must bounce.
      repeat (QUEUE_DEPTH) send_item(random_submit());
      send_item(submit_of(32'hFFFF_FFFF, 8'hAA, 8'h55, 1'b1));
      wait_all_issued();

      counted = 0;
      phase = 0;
      while (counted < ITEM_TARGET) begin
         steady = (phase % 7 == 3);
         case (phase % 4)
            0: submit_pct = 50;
            1: submit_pct = 85;
            2: submit_pct = 15;
            default: submit_pct = 55;
         endcase
         if (phase == 5 || phase == 10) hold_request = 1'b1;
         span = $urandom_range(20, 60);
         repeat (span) begin
            do_submit = ($urandom_range(99) < submit_pct);
            // Completions on an empty queue are kept as occasional noise only.
            if (queue_level == 0 && !do_submit && $urandom_range(99) >= 10) do_submit = 1'b1;
            if (do_submit || queue_level != 0) counted++;
            item = do_submit ? random_submit() : completion();
            send_item(item);
         end
         if (phase % 3 == 2) wait_all_issued();
         phase++;
      end

      req_valid <= 1'b0;
      waited = 0;
      while (pending_count != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+sv
sv/ers_pkg.sv
sv/ers_cell.sv
sv/elevator_request_scheduler.sv
tb/sv/scan_issue_checker.sv
tb/sv/tb_elevator_request_scheduler.sv
